### sv/gdfw_pkg.sv
package gdfw_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_EDGES    = 256;
	localparam int STACK_SLOTS  = MAX_EDGES + 1;

	// fixed field widths
	localparam int FUNC_W = 2;
	localparam int SLOT_W = 8;
	localparam int VAL_W  = 9;
	localparam int VID_W  = 6;
	localparam int CFG_W  = 7;
	localparam int OFF_W  = 9;

	// derived storage widths
	localparam int VIS_AW  = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
	localparam int ROW_AW  = $clog2(MAX_VERTICES + 1);
	localparam int EDGE_AW = (MAX_EDGES > 2) ? $clog2(MAX_EDGES) : 1;
	localparam int STK_AW  = $clog2(STACK_SLOTS);
	localparam int SP_W    = $clog2(STACK_SLOTS + 1);

	localparam logic [FUNC_W-1:0] FUNC_ROW   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_EDGE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_START = 2'd2;

	typedef struct packed {
		logic             valid;
		logic [VID_W-1:0] vertex;
		logic             last;
		logic             bad_start;
	} res_t;

endpackage

### sv/gdfw_core.sv
module gdfw_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gdfw_pkg::FUNC_W-1:0]   func,
	input  logic [gdfw_pkg::SLOT_W-1:0]   slot,
	input  logic [gdfw_pkg::VAL_W-1:0]    value,
	input  logic [gdfw_pkg::CFG_W-1:0]    count,
	input  logic                          out_free,
	output gdfw_pkg::res_t                res
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_BAD    = 9'b000000010,
		S_POP    = 9'b000000100,
		S_CHECK  = 9'b000001000,
		S_ROW0   = 9'b000010000,
		S_ROW1   = 9'b000100000,
		S_EDGE   = 9'b001000000,
		S_PUSH   = 9'b010000000,
		S_FINISH = 9'b100000000
	} state_t;

	state_t state_q;

	logic [gdfw_pkg::OFF_W-1:0] row_mem   [gdfw_pkg::MAX_VERTICES+1];
	logic [gdfw_pkg::VID_W-1:0] edge_mem  [gdfw_pkg::MAX_EDGES];
	logic [gdfw_pkg::VID_W-1:0] stack_mem [gdfw_pkg::STACK_SLOTS];
	logic [gdfw_pkg::MAX_VERTICES-1:0] visited_q;

	logic [gdfw_pkg::OFF_W-1:0]  row_rd_q;
	logic [gdfw_pkg::VID_W-1:0]  edge_rd_q;
	logic [gdfw_pkg::VID_W-1:0]  stack_rd_q;
	logic [gdfw_pkg::SP_W-1:0]   sp_q;
	logic [gdfw_pkg::OFF_W-1:0]  begin_q;
	logic [gdfw_pkg::OFF_W-1:0]  i_q;
	logic [gdfw_pkg::VID_W-1:0]  cur_q;
	logic [gdfw_pkg::VID_W-1:0]  pend_q;
	logic                        have_pend_q;

	logic                        accept;
	logic                        start_ok;
	logic [gdfw_pkg::ROW_AW-1:0] row_raddr;
	logic                        row_we;
	logic                        edge_we;
	logic                        stk_we;
	logic [gdfw_pkg::STK_AW-1:0] stk_waddr;
	logic [gdfw_pkg::VID_W-1:0]  stk_wdata;
	logic [gdfw_pkg::VID_W-1:0]  probe;
	logic                        probe_ok;
	logic                        edge_left;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign start_ok = value < gdfw_pkg::VAL_W'(count);
	assign edge_left = i_q > begin_q;

	// one visited/range probe shared by the pop check and the push check
	always_comb begin
		probe    = (state_q == S_PUSH) ? edge_rd_q : stack_rd_q;
		probe_ok = ({1'b0, probe} < count) &&
			!visited_q[gdfw_pkg::VIS_AW'(probe)];
	end

	always_comb begin
		row_raddr = (state_q == S_CHECK) ? gdfw_pkg::ROW_AW'(stack_rd_q) :
			gdfw_pkg::ROW_AW'(cur_q) + gdfw_pkg::ROW_AW'(1);
		row_we  = accept && (func == gdfw_pkg::FUNC_ROW) &&
			(int'(slot) <= gdfw_pkg::MAX_VERTICES);
		edge_we = accept && (func == gdfw_pkg::FUNC_EDGE) &&
			(int'(slot) < gdfw_pkg::MAX_EDGES);
		stk_we    = 1'b0;
		stk_waddr = gdfw_pkg::STK_AW'(sp_q);
		stk_wdata = edge_rd_q;
		if (accept && func == gdfw_pkg::FUNC_START && start_ok) begin
			stk_we    = 1'b1;
			stk_waddr = '0;
			stk_wdata = value[gdfw_pkg::VID_W-1:0];
		end else if (state_q == S_PUSH && probe_ok &&
				int'(sp_q) < gdfw_pkg::STACK_SLOTS) begin
			stk_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (row_we)
			row_mem[gdfw_pkg::ROW_AW'(slot)] <= value;
		row_rd_q <= row_mem[row_raddr];
	end

	always_ff @(posedge clk) begin
		if (edge_we)
			edge_mem[gdfw_pkg::EDGE_AW'(slot)] <= value[gdfw_pkg::VID_W-1:0];
		edge_rd_q <= edge_mem[gdfw_pkg::EDGE_AW'(i_q - gdfw_pkg::OFF_W'(1))];
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stack_mem[stk_waddr] <= stk_wdata;
		// popped entry is held while the check waits on the output register
		if (state_q == S_POP && sp_q != '0)
			stack_rd_q <= stack_mem[gdfw_pkg::STK_AW'(sp_q - gdfw_pkg::SP_W'(1))];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ROW0)
			begin_q <= row_rd_q;
		if (state_q == S_ROW1)
			i_q <= (int'(row_rd_q) > gdfw_pkg::MAX_EDGES) ?
				gdfw_pkg::OFF_W'(gdfw_pkg::MAX_EDGES) : row_rd_q;
		else if (state_q == S_EDGE && edge_left)
			i_q <= i_q - gdfw_pkg::OFF_W'(1);
		if (state_q == S_CHECK)
			cur_q <= stack_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			visited_q   <= '0;
			sp_q        <= '0;
			have_pend_q <= 1'b0;
			pend_q      <= '0;
			res         <= '0;
		end else begin
			res.valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && func == gdfw_pkg::FUNC_START) begin
						if (start_ok) begin
							visited_q   <= '0;
							sp_q        <= gdfw_pkg::SP_W'(1);
							have_pend_q <= 1'b0;
							state_q     <= S_POP;
						end else begin
							state_q <= S_BAD;
						end
					end
				end
				S_BAD: begin
					if (out_free) begin
						res     <= '{valid: 1'b1, vertex: '0, last: 1'b1, bad_start: 1'b1};
						state_q <= S_IDLE;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						state_q <= S_FINISH;
					end else begin
						sp_q    <= sp_q - gdfw_pkg::SP_W'(1);
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (!probe_ok) begin
						state_q <= S_POP;
					end else if (!have_pend_q || out_free) begin
						// previous visit is now known not to be the last one
						if (have_pend_q)
							res <= '{valid: 1'b1, vertex: pend_q, last: 1'b0, bad_start: 1'b0};
						pend_q      <= stack_rd_q;
						have_pend_q <= 1'b1;
						visited_q[gdfw_pkg::VIS_AW'(stack_rd_q)] <= 1'b1;
						state_q     <= S_ROW0;
					end
				end
				S_ROW0:  state_q <= S_ROW1;
				S_ROW1:  state_q <= S_EDGE;
				S_EDGE:  state_q <= edge_left ? S_PUSH : S_POP;
				S_PUSH: begin
					if (stk_we)
						sp_q <= sp_q + gdfw_pkg::SP_W'(1);
					state_q <= S_EDGE;
				end
				S_FINISH: begin
					if (out_free) begin
						res     <= '{valid: 1'b1, vertex: pend_q, last: 1'b1, bad_start: 1'b0};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(sp_q) <= gdfw_pkg::STACK_SLOTS)
		else $error("stack pointer past stack size");

	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH || state_q == S_BAD) && out_free |=> res.valid && res.last)
		else $error("final result not issued");

	a_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.bad_start |-> res.last && res.vertex == '0)
		else $error("bad start result malformed");

	a_edge_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EDGE && edge_left |=> state_q == S_PUSH && i_q == $past(i_q) - 1'b1)
		else $error("edge walk did not step");

	a_finish_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH |-> have_pend_q)
		else $error("walk finished without a visit");

endmodule

### sv/graph_depth_first_walk_top.sv
// Depth-first walk over a graph in compressed-row form.
// Input channel (in_valid/in_ready, func/slot/value): func 0 writes one row
// offset, func 1 one edge target, func 2 starts a walk from vertex value.
// Loads give no result. A walk gives one result per newly visited vertex in
// visit order, last set on the final one; a start vertex not below the vertex
// count gives a single result with bad_start and last set.
// Config channel (cfg_valid/cfg_ready, cfg_data) writes vertex_count; always
// ready, to be written only while the block is idle. Reset value 64.
// in_ready is low for the whole of a walk. The sequencer pops a stack entry,
// checks it, reads the two row offsets of each newly visited vertex, then
// steps through its edges from last to first, pushing each target that is in
// range and not yet visited while the stack has room.
// Results leave through a one-entry output register; if the receiver stalls
// the walk pauses at its next result until the register is taken.
// Reset (arst_n, asynchronous) clears the sequencer, visited marks, stack
// pointer and output valid; the offset and edge tables are not cleared.
module graph_depth_first_walk_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [gdfw_pkg::FUNC_W-1:0]  func,
	input  logic [gdfw_pkg::SLOT_W-1:0]  slot,
	input  logic [gdfw_pkg::VAL_W-1:0]   value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gdfw_pkg::VID_W-1:0]   vertex,
	output logic                         last,
	output logic                         bad_start,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [gdfw_pkg::CFG_W-1:0]   cfg_data
);

	logic [gdfw_pkg::CFG_W-1:0] vcount_q;
	logic [gdfw_pkg::CFG_W-1:0] count_eff;
	logic                       out_free;
	gdfw_pkg::res_t             res;

	assign cfg_ready = 1'b1;
	assign count_eff = (int'(vcount_q) > gdfw_pkg::MAX_VERTICES) ?
		gdfw_pkg::CFG_W'(gdfw_pkg::MAX_VERTICES) : vcount_q;
	assign out_free  = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vcount_q <= gdfw_pkg::CFG_W'(64);
		else if (cfg_valid && cfg_ready)
			vcount_q <= cfg_data;
	end

	gdfw_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.slot     (slot),
		.value    (value),
		.count    (count_eff),
		.out_free (out_free),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (res.valid)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			vertex    <= res.vertex;
			last      <= res.last;
			bad_start <= res.bad_start;
		end
	end

endmodule

### test/dfs_visit_checker.sv
`timescale 1ns / 100ps

module dfs_visit_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [gdfw_pkg::FUNC_W-1:0] func,
	input  logic [gdfw_pkg::SLOT_W-1:0] slot,
	input  logic [gdfw_pkg::VAL_W-1:0]  value,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [gdfw_pkg::VID_W-1:0]  vertex,
	input  logic                        last,
	input  logic                        bad_start,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [gdfw_pkg::CFG_W-1:0]  cfg_data,
	output int                          fail_count,
	output int                          pending
);

	typedef struct packed {
		logic [gdfw_pkg::VID_W-1:0] vertex;
		logic                       last;
		logic                       bad_start;
	} visit_t;

	logic [gdfw_pkg::OFF_W-1:0] row_tab [gdfw_pkg::MAX_VERTICES+1];
	logic [gdfw_pkg::VID_W-1:0] edge_tab [gdfw_pkg::MAX_EDGES];
	logic [gdfw_pkg::CFG_W-1:0] vcount = gdfw_pkg::CFG_W'(gdfw_pkg::MAX_VERTICES);
	visit_t                     visit_q [$];
	int                         errs = 0;
	int                         backlog = 0;

	assign fail_count = errs;
	assign pending    = backlog;

	initial begin
		foreach (row_tab[i])
			row_tab[i] = '0;
		foreach (edge_tab[i])
			edge_tab[i] = '0;
	end

	function automatic void note_fault(input string what, input int want, input int got);
		errs++;
		if (errs <= 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
	endfunction

	function automatic void queue_visit(input visit_t v);
		visit_q.insert(visit_q.size(), v);
	endfunction

	// visit order of a depth-first walk, queued as expected results
	function automatic void predict_walk(input int origin);
		int     lim, depth, cur, lo, hi, nb, n;
		bit     seen [gdfw_pkg::MAX_VERTICES];
		int     stk [gdfw_pkg::STACK_SLOTS];
		visit_t found [gdfw_pkg::MAX_VERTICES];
		lim = (vcount > gdfw_pkg::MAX_VERTICES) ? gdfw_pkg::MAX_VERTICES : int'(vcount);
		if (origin >= lim) begin
			queue_visit('{vertex: '0, last: 1'b1, bad_start: 1'b1});
			return;
		end
		foreach (seen[i])
			seen[i] = 1'b0;
		n = 0;
		depth = 1;
		stk[0] = origin;
		while (depth > 0) begin
			depth--;
			cur = stk[depth];
			if (cur >= lim || seen[cur])
				continue;
			seen[cur] = 1'b1;
			found[n] = '{vertex: gdfw_pkg::VID_W'(cur), last: 1'b0, bad_start: 1'b0};
			n++;
			lo = row_tab[cur];
			hi = row_tab[cur+1];
			if (hi > gdfw_pkg::MAX_EDGES)
				hi = gdfw_pkg::MAX_EDGES;
			// reverse list order so the first neighbour is popped first; full stack drops
			for (int i = hi; i > lo; i--) begin
				nb = edge_tab[i-1];
				if (nb < lim && !seen[nb] && depth < gdfw_pkg::STACK_SLOTS) begin
					stk[depth] = nb;
					depth++;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			found[i].last = (i == n - 1);
			queue_visit(found[i]);
		end
	endfunction

	always @(posedge clk) begin
		visit_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (visit_q.size() == 0) begin
					note_fault("unexpected result, vertex", -1, vertex);
				end else begin
					want = visit_q.pop_front();
					if (vertex !== want.vertex)
						note_fault("vertex", want.vertex, vertex);
					if (last !== want.last)
						note_fault("last", want.last, last);
					if (bad_start !== want.bad_start)
						note_fault("bad_start", want.bad_start, bad_start);
				end
			end
			// an item taken on this edge still sees the old vertex count
			if (in_valid && in_ready) begin
				case (func)
					gdfw_pkg::FUNC_ROW: begin
						if (slot <= gdfw_pkg::MAX_VERTICES)
							row_tab[gdfw_pkg::ROW_AW'(slot)] = value;
					end
					gdfw_pkg::FUNC_EDGE: begin
						if (slot < gdfw_pkg::MAX_EDGES)
							edge_tab[slot] = value[gdfw_pkg::VID_W-1:0];
					end
					gdfw_pkg::FUNC_START: begin
						predict_walk(int'(value));
					end
					default: ;
				endcase
			end
			if (cfg_valid && cfg_ready)
				vcount = cfg_data;
		end
		backlog <= visit_q.size();
	end

endmodule

### test/graph_depth_first_walk_top_tb.sv
`timescale 1ns / 100ps

module graph_depth_first_walk_top_tb;

	localparam int HOLD_AT         = 150;
	localparam int HOLD_LEN        = 300;
	localparam int STALL_LIMIT     = 20000;
	localparam int SETTLE          = 16;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 22;
	// spare code, the block must ignore it
	localparam logic [gdfw_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [gdfw_pkg::FUNC_W-1:0] func = '0;
	logic [gdfw_pkg::SLOT_W-1:0] slot = '0;
	logic [gdfw_pkg::VAL_W-1:0]  value = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [gdfw_pkg::VID_W-1:0]  vertex;
	logic                        last;
	logic                        bad_start;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [gdfw_pkg::CFG_W-1:0]  cfg_data = '0;
	int                          fail_count;
	int                          pending;
	int                          quiet_cycles = 0;
	bit                          tx_quiet = 1'b0;
	int                          row_pos [gdfw_pkg::MAX_VERTICES+1];

	always #5 clk = ~clk;

	graph_depth_first_walk_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.slot      (slot),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.vertex    (vertex),
		.last      (last),
		.bad_start (bad_start),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	dfs_visit_checker walk_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.slot       (slot),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.vertex     (vertex),
		.last       (last),
		.bad_start  (bad_start),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// watchdog: cycles without any transfer on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_item(input logic [gdfw_pkg::FUNC_W-1:0] f,
			input logic [gdfw_pkg::SLOT_W-1:0] s, input logic [gdfw_pkg::VAL_W-1:0] v);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		slot     <= s;
		value    <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// returns once every expected result is in and the block has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_vertex_count(input int vc);
		cfg_valid <= 1'b1;
		cfg_data  <= gdfw_pkg::CFG_W'(vc);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// mostly ascending offsets with short rows; now and then a wild entry
	task automatic load_rows();
		int                         pos;
		logic [gdfw_pkg::VAL_W-1:0] v;
		pos = $urandom_range(0, 4);
		for (int r = 0; r <= gdfw_pkg::MAX_VERTICES; r++) begin
			row_pos[r] = pos;
			if ($urandom_range(0, 24) == 0)
				v = gdfw_pkg::VAL_W'($urandom_range(0, 511));
			else
				v = gdfw_pkg::VAL_W'(pos);
			send_item(gdfw_pkg::FUNC_ROW, gdfw_pkg::SLOT_W'(r), v);
			pos += $urandom_range(0, 6);
		end
	endtask

	task automatic random_items(input int n, input int lim);
		int                         done, pick, s;
		logic [gdfw_pkg::VAL_W-1:0] v;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				if (lim > 0 && $urandom_range(0, 7) != 0)
					v = gdfw_pkg::VAL_W'($urandom_range(0, lim - 1));
				else
					v = gdfw_pkg::VAL_W'($urandom_range(0, 511));
				send_item(gdfw_pkg::FUNC_START, gdfw_pkg::SLOT_W'($urandom_range(0, 255)), v);
				done++;
			end else if (pick < 65) begin
				send_item(gdfw_pkg::FUNC_EDGE, gdfw_pkg::SLOT_W'($urandom_range(0, 255)),
					gdfw_pkg::VAL_W'($urandom_range(0, 511)));
				done++;
			end else if (pick < 85) begin
				s = $urandom_range(0, gdfw_pkg::MAX_VERTICES);
				if ($urandom_range(0, 9) == 0)
					v = gdfw_pkg::VAL_W'($urandom_range(0, 511));
				else
					v = gdfw_pkg::VAL_W'(row_pos[s] + $urandom_range(0, 2));
				send_item(gdfw_pkg::FUNC_ROW, gdfw_pkg::SLOT_W'(s), v);
				done++;
			end else if (pick < 92) begin
				send_item(gdfw_pkg::FUNC_ROW,
					gdfw_pkg::SLOT_W'($urandom_range(gdfw_pkg::MAX_VERTICES + 1, 255)),
					gdfw_pkg::VAL_W'($urandom_range(0, 511)));
			end else begin
				send_item(FUNC_SPARE, gdfw_pkg::SLOT_W'($urandom_range(0, 255)),
					gdfw_pkg::VAL_W'($urandom_range(0, 511)));
			end
		end
	endtask

	// result side: random back-pressure, quiet stretches, one long hold-off
	initial begin
		int  gap, taken;
		bit  rx_quiet;
		taken = 0;
		rx_quiet = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = rx_quiet ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
			if (taken == HOLD_AT) begin
				out_ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end
			if (taken % 40 == 0)
				rx_quiet = ($urandom_range(0, 2) == 0);
		end
	end

	initial begin
		int vc;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both tables written in full before any walk
		for (int e = 0; e < gdfw_pkg::MAX_EDGES; e++)
			send_item(gdfw_pkg::FUNC_EDGE, gdfw_pkg::SLOT_W'(e),
				gdfw_pkg::VAL_W'($urandom_range(0, 511)));
		load_rows();

		send_item(gdfw_pkg::FUNC_START, 8'd0, 9'd0);
		send_item(gdfw_pkg::FUNC_START, 8'd255, 9'd63);
		send_item(gdfw_pkg::FUNC_START, 8'd0, 9'd64);
		send_item(gdfw_pkg::FUNC_START, 8'd0, 9'd511);
		send_item(FUNC_SPARE, 8'd255, 9'd511);
		send_item(gdfw_pkg::FUNC_ROW, 8'd65, 9'd0);
		send_item(gdfw_pkg::FUNC_ROW, 8'd255, 9'd511);
		// last row runs past the edge list
		send_item(gdfw_pkg::FUNC_ROW, 8'd64, 9'd511);
		send_item(gdfw_pkg::FUNC_EDGE, 8'd255, 9'd511);
		send_item(gdfw_pkg::FUNC_START, 8'd0, 9'd63);
		// reversed row: vertex 5 has no neighbours
		send_item(gdfw_pkg::FUNC_ROW, 8'd5, 9'd200);
		send_item(gdfw_pkg::FUNC_ROW, 8'd6, 9'd3);
		send_item(gdfw_pkg::FUNC_START, 8'd0, 9'd5);
		// two rows spanning the whole list, linked first: the stack overflows
		send_item(gdfw_pkg::FUNC_ROW, 8'd10, 9'd0);
		send_item(gdfw_pkg::FUNC_ROW, 8'd11, 9'd256);
		send_item(gdfw_pkg::FUNC_ROW, 8'd20, 9'd0);
		send_item(gdfw_pkg::FUNC_ROW, 8'd21, 9'd256);
		send_item(gdfw_pkg::FUNC_EDGE, 8'd0, 9'd20);
		send_item(gdfw_pkg::FUNC_START, 8'd0, 9'd10);

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				0:       vc = 1;
				1:       vc = 0;
				2:       vc = 127;
				3:       vc = $urandom_range(2, 63);
				4:       vc = $urandom_range(gdfw_pkg::MAX_VERTICES + 1, 126);
				default: vc = gdfw_pkg::MAX_VERTICES;
			endcase
			set_vertex_count(vc);
			tx_quiet = (p % 2 == 1);
			random_items(ITEMS_PER_PHASE,
				(vc > gdfw_pkg::MAX_VERTICES) ? gdfw_pkg::MAX_VERTICES : vc);
		end
		wait_idle();

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
